// ===== src/kms_pkg.sv =====
package kms_pkg;

    // Keypad geometry limits.
    localparam int MAX_COLUMNS = 10;
    localparam int MAX_ROWS    = 10;

    // Field widths.
    localparam int DRIVE_W   = 10;
    localparam int ROWS_W    = 10;
    localparam int CODE_W    = 7;
    localparam int WAIT_W    = 16;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Packed stream widths, filled up to whole bytes.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Register reset values.
    localparam logic [WAIT_W-1:0] DEFAULT_DEBOUNCE = 16'd20;
    localparam logic [IDX_W-1:0]  DEFAULT_COLUMNS  = 4'(MAX_COLUMNS);
    localparam logic [IDX_W-1:0]  DEFAULT_ROWS     = 4'(MAX_ROWS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd2;

    // Item kinds carried on the input tuser.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Scanner phases.
    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_CHECK      = 5'b00010,
        PH_PRESS_WAIT = 5'b00100,
        PH_RELEASE    = 5'b01000,
        PH_AFTER_WAIT = 5'b10000
    } t_phase;

    // Live configuration.
    typedef struct packed {
        logic [WAIT_W-1:0] debounce_ticks;
        logic [IDX_W-1:0]  active_columns;
        logic [IDX_W-1:0]  active_rows;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [CODE_W-1:0]  key_code;
        logic               key_found;
        logic               scan_done;
        logic [DRIVE_W-1:0] column_drive;
    } t_result;

    // Zero counts as one, anything above the maximum counts as the maximum.
    function automatic logic [IDX_W-1:0] clamp_count(input logic [IDX_W-1:0] v,
                                                      input logic [IDX_W-1:0] maxv);
        logic [IDX_W-1:0] r;
        if (v == '0) begin
            r = 4'd1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Key code is column times ten plus row.
    function automatic logic [CODE_W-1:0] make_code(input logic [IDX_W-1:0] col,
                                                     input logic [IDX_W-1:0] row);
        logic [CODE_W:0] sum;
        sum = {1'b0, col, 3'b000} + {3'b000, col, 1'b0} + {4'b0000, row};
        return sum[CODE_W-1:0];
    endfunction

endpackage

// ===== src/kms_cfg_regs.sv =====
module kms_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [kms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kms_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output kms_pkg::t_cfg                      o_cfg
);

    kms_pkg::t_cfg r_cfg;
    kms_pkg::t_cfg n_cfg;

    // Register write decode; an index beyond the list writes nothing.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                kms_pkg::CFG_DEBOUNCE: n_cfg.debounce_ticks = i_cfg_data;
                kms_pkg::CFG_COLUMNS:  n_cfg.active_columns = i_cfg_data[kms_pkg::IDX_W-1:0];
                kms_pkg::CFG_ROWS:     n_cfg.active_rows    = i_cfg_data[kms_pkg::IDX_W-1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= kms_pkg::DEFAULT_DEBOUNCE;
            r_cfg.active_columns <= kms_pkg::DEFAULT_COLUMNS;
            r_cfg.active_rows    <= kms_pkg::DEFAULT_ROWS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/kms_scan_core.sv =====
module kms_scan_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic                            i_kind,
    input  logic [kms_pkg::ROWS_W-1:0]      i_row_levels,
    input  kms_pkg::t_cfg                   i_cfg,
    output kms_pkg::t_result                o_result
);

    kms_pkg::t_phase                r_phase;
    logic [kms_pkg::IDX_W-1:0]      r_col;
    logic [kms_pkg::IDX_W-1:0]      r_row;
    logic [kms_pkg::WAIT_W-1:0]     r_wait;
    logic [kms_pkg::CODE_W-1:0]     r_code;
    logic                           r_found;

    kms_pkg::t_phase                n_phase;
    logic [kms_pkg::IDX_W-1:0]      n_col;
    logic [kms_pkg::IDX_W-1:0]      n_row;
    logic [kms_pkg::WAIT_W-1:0]     n_wait;
    logic [kms_pkg::CODE_W-1:0]     n_code;
    logic                           n_found;
    logic                           done;

    logic [kms_pkg::IDX_W-1:0]      rows_lim;
    logic [kms_pkg::IDX_W-1:0]      cols_lim;
    logic [kms_pkg::IDX_W-1:0]      adv_row;
    logic [kms_pkg::IDX_W-1:0]      adv_col;
    logic                           row_wrap;
    logic                           sweep_end;
    logic [15:0]                    levels_ext;
    logic                           pressed;
    logic [kms_pkg::WAIT_W-1:0]     wait_dec;
    logic                           debounce_zero;
    logic [15:0]                    drive_ext;

    // Row and column advance, shared by every place that ends a row.
    always_comb begin
        rows_lim  = kms_pkg::clamp_count(i_cfg.active_rows, kms_pkg::DEFAULT_ROWS);
        cols_lim  = kms_pkg::clamp_count(i_cfg.active_columns, kms_pkg::DEFAULT_COLUMNS);
        adv_row   = r_row + 4'd1;
        adv_col   = r_col + 4'd1;
        row_wrap  = (adv_row >= rows_lim);
        sweep_end = row_wrap && (adv_col >= cols_lim);
    end

    // Examined row level; rows beyond the pins read as pressed.
    assign levels_ext    = {{(16-kms_pkg::ROWS_W){1'b0}}, i_row_levels};
    assign pressed       = ~levels_ext[r_row];
    assign wait_dec      = r_wait - 16'd1;
    assign debounce_zero = (i_cfg.debounce_ticks == '0);

    // Next-state logic for one accepted item.
    always_comb begin
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_wait  = r_wait;
        n_code  = r_code;
        n_found = r_found;
        done    = 1'b0;

        if (i_kind == kms_pkg::KIND_START) begin
            // A start request only matters when idle.
            if (r_phase == kms_pkg::PH_IDLE) begin
                n_col   = '0;
                n_row   = '0;
                n_wait  = '0;
                n_code  = '0;
                n_found = 1'b0;
                n_phase = kms_pkg::PH_CHECK;
            end
        end else begin
            unique case (r_phase)
                kms_pkg::PH_IDLE: begin
                    n_phase = kms_pkg::PH_IDLE;
                end
                kms_pkg::PH_CHECK: begin
                    if (pressed) begin
                        if (debounce_zero) begin
                            n_phase = kms_pkg::PH_RELEASE;
                        end else begin
                            n_wait  = i_cfg.debounce_ticks;
                            n_phase = kms_pkg::PH_PRESS_WAIT;
                        end
                    end else begin
                        done = sweep_end;
                    end
                end
                kms_pkg::PH_PRESS_WAIT: begin
                    n_wait = wait_dec;
                    if (wait_dec == '0) begin
                        n_phase = kms_pkg::PH_RELEASE;
                    end
                end
                kms_pkg::PH_RELEASE: begin
                    if (!pressed) begin
                        n_code  = kms_pkg::make_code(r_col, r_row);
                        n_found = 1'b1;
                        if (!debounce_zero) begin
                            n_wait  = i_cfg.debounce_ticks;
                            n_phase = kms_pkg::PH_AFTER_WAIT;
                        end else begin
                            done = sweep_end;
                        end
                    end
                end
                kms_pkg::PH_AFTER_WAIT: begin
                    n_wait = wait_dec;
                    if (wait_dec == '0) begin
                        done = sweep_end;
                    end
                end
                default: begin
                    n_phase = kms_pkg::PH_IDLE;
                end
            endcase

            // Every path that ends a row steps to the next row or column, or back to idle when the sweep ends.
            if ((r_phase == kms_pkg::PH_CHECK && !pressed) ||
                (r_phase == kms_pkg::PH_RELEASE && !pressed && debounce_zero) ||
                (r_phase == kms_pkg::PH_AFTER_WAIT && wait_dec == '0)) begin
                if (row_wrap) begin
                    n_row = '0;
                    if (sweep_end) begin
                        n_col   = '0;
                        n_phase = kms_pkg::PH_IDLE;
                    end else begin
                        n_col   = adv_col;
                        n_phase = kms_pkg::PH_CHECK;
                    end
                end else begin
                    n_row   = adv_row;
                    n_phase = kms_pkg::PH_CHECK;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= kms_pkg::PH_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_wait  <= '0;
            r_code  <= '0;
            r_found <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_wait  <= n_wait;
            r_code  <= n_code;
            r_found <= n_found;
        end
    end

    // Result of this item, showing the drive after the step.
    assign drive_ext = ~(16'd1 << n_col);
    always_comb begin
        o_result.column_drive = (n_phase == kms_pkg::PH_IDLE) ? '1
                                                              : drive_ext[kms_pkg::DRIVE_W-1:0];
        o_result.scan_done    = done;
        o_result.key_found    = done & n_found;
        o_result.key_code     = done ? n_code : '0;
    end

endmodule

// ===== src/keypad_matrix_scanner_unit.sv =====
// Matrix keypad scanner with debounce. A start transfer (tuser 0) while idle
// begins a sweep over the columns; tick transfers (tuser 1) step through the
// rows of the driven column, examining a row, debouncing a press, waiting for
// release, recording the code column*10+row and debouncing again. Every input
// transfer yields exactly one result transfer, which shows the column drive
// after that item; the result that ends the sweep carries scan_done with
// key_found and the last key code. The block takes one item per clock cycle
// while the result side is not stalled; an item is held in the input register
// and its result in the result register, and the scanner state is updated in
// a single step between them. The configuration registers are read live by
// the scanner, so they should be written only while no transfer is in flight.
module keypad_matrix_scanner_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [kms_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [9:0] row_levels
    input  logic                                 s_axis_tuser,  // [0] kind
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [9:0] column_drive, [10] scan_done, [11] key_found, [18:12] key_code
    output logic [kms_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // Configuration writes.
    input  logic                                 i_cfg_we,
    input  logic [kms_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [kms_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    kms_pkg::t_cfg                   cfg;
    kms_pkg::t_result                result;

    logic                            r_in_valid;
    logic                            r_in_kind;
    logic [kms_pkg::ROWS_W-1:0]      r_in_rows;
    logic                            r_out_valid;
    kms_pkg::t_result                r_out;
    logic                            step;

    kms_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The held item moves on when the result register is free or drains now.
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser;
            r_in_rows <= s_axis_tdata[kms_pkg::ROWS_W-1:0];
        end
    end

    kms_scan_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_kind       (r_in_kind),
        .i_row_levels (r_in_rows),
        .i_cfg        (cfg),
        .o_result     (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(kms_pkg::OUT_TDATA_W - $bits(kms_pkg::t_result)){1'b0}}, r_out};

endmodule

// ===== src/kms_checker.sv =====
module kms_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [kms_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Key information only appears on the result that ends a sweep.
    a_key_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[11] || m_axis_tdata[18:12] != 7'd0)
        |-> m_axis_tdata[10])
        else $error("key reported without scan_done");

    // A finished sweep releases all columns.
    a_idle_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[9:0] == 10'h3FF)
        else $error("column still driven after sweep end");

    // At most one column is driven low.
    a_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(~m_axis_tdata[9:0]))
        else $error("more than one column driven");

    // An offered input is only held off while a result waits on the receiver.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while the result side is free");

endmodule

bind keypad_matrix_scanner_unit kms_checker u_kms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTING_ITEMS = 25;
    localparam int DRAIN_CYCLES  = 8;
    localparam logic [kms_pkg::DRIVE_W-1:0] DRIVE_IDLE = '1;
    localparam logic [kms_pkg::DRIVE_W-1:0] DRIVE_BIT0 = {{(kms_pkg::DRIVE_W-1){1'b0}}, 1'b1};

    // One row of the directed plan: either a register setting or one item.
    typedef struct {
        bit                         is_cfg;
        logic [kms_pkg::WAIT_W-1:0] deb;
        logic [kms_pkg::IDX_W-1:0]  cols;
        logic [kms_pkg::IDX_W-1:0]  rows;
        logic                       kind;
        logic [kms_pkg::ROWS_W-1:0] levels;
        bit                         typed;
        kms_pkg::t_result           res;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [kms_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [9:0] row_levels
    logic                            s_axis_tuser = 1'b0; // [0] kind
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [9:0] column_drive, [10] scan_done, [11] key_found, [18:12] key_code
    logic [kms_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            i_cfg_we = 1'b0;
    logic [kms_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [kms_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Scanner state as the testbench tracks it.
    kms_pkg::t_phase            sc_phase;
    logic [kms_pkg::IDX_W-1:0]  sc_col;
    logic [kms_pkg::IDX_W-1:0]  sc_row;
    logic [kms_pkg::WAIT_W-1:0] sc_wait;
    logic [kms_pkg::CODE_W-1:0] sc_code;
    logic                       sc_found;
    kms_pkg::t_cfg              cfg;

    kms_pkg::t_result scan_results_due[$];
    t_plan_row        plan[$];

    int tx_idle_pct;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int error_count = 0;
    int cycle_count = 0;

    keypad_matrix_scanner_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // A count of zero scans one line, a count above the keypad size scans all.
    function automatic logic [kms_pkg::IDX_W-1:0] effective_span(
            input logic [kms_pkg::IDX_W-1:0] v, input int limit);
        if (v == 0) begin
            return 4'd1;
        end else if (v > limit) begin
            return limit[kms_pkg::IDX_W-1:0];
        end
        return v;
    endfunction

    // Step to the next row, wrapping into the next column; true when the sweep ends.
    function automatic bit step_position();
        sc_row = sc_row + 1'b1;
        if (sc_row >= effective_span(cfg.active_rows, kms_pkg::MAX_ROWS)) begin
            sc_row = '0;
            sc_col = sc_col + 1'b1;
            if (sc_col >= effective_span(cfg.active_columns, kms_pkg::MAX_COLUMNS)) begin
                sc_col = '0;
                sc_phase = kms_pkg::PH_IDLE;
                return 1'b1;
            end
        end
        sc_phase = kms_pkg::PH_CHECK;
        return 1'b0;
    endfunction

    // The key has been let go: record it and start the second debounce, or step on if the debounce is zero.
    function automatic bit record_key();
        sc_code = 7'(sc_col) * 7'd10 + 7'(sc_row);
        sc_found = 1'b1;
        if (cfg.debounce_ticks == 0) begin
            return step_position();
        end
        sc_wait = cfg.debounce_ticks;
        sc_phase = kms_pkg::PH_AFTER_WAIT;
        return 1'b0;
    endfunction

    // Works out the result of one item and advances the tracked scanner state.
    function automatic kms_pkg::t_result predict_scan_step(input logic kind,
            input logic [kms_pkg::ROWS_W-1:0] levels);
        kms_pkg::t_result r;
        bit               done;
        done = 1'b0;
        if (kind == kms_pkg::KIND_START) begin
            // A start while a sweep runs changes nothing.
            if (sc_phase == kms_pkg::PH_IDLE) begin
                sc_col   = '0;
                sc_row   = '0;
                sc_wait  = '0;
                sc_code  = '0;
                sc_found = 1'b0;
                sc_phase = kms_pkg::PH_CHECK;
            end
        end else begin
            case (sc_phase)
                kms_pkg::PH_CHECK: begin
                    if (!levels[sc_row]) begin
                        if (cfg.debounce_ticks == 0) begin
                            sc_phase = kms_pkg::PH_RELEASE;
                        end else begin
                            sc_wait  = cfg.debounce_ticks;
                            sc_phase = kms_pkg::PH_PRESS_WAIT;
                        end
                    end else begin
                        done = step_position();
                    end
                end
                kms_pkg::PH_PRESS_WAIT: begin
                    sc_wait = sc_wait - 1'b1;
                    if (sc_wait == 0) sc_phase = kms_pkg::PH_RELEASE;
                end
                kms_pkg::PH_RELEASE: begin
                    if (levels[sc_row]) done = record_key();
                end
                kms_pkg::PH_AFTER_WAIT: begin
                    sc_wait = sc_wait - 1'b1;
                    if (sc_wait == 0) done = step_position();
                end
                default: begin
                    // Ticks while idle are ignored.
                end
            endcase
        end
        r.column_drive = (sc_phase == kms_pkg::PH_IDLE) ? DRIVE_IDLE : ~(DRIVE_BIT0 << sc_col);
        r.scan_done    = done;
        r.key_found    = done ? sc_found : 1'b0;
        r.key_code     = done ? sc_code : '0;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Offers one item, waits for its transfer and queues the expected result.
    task automatic send_item(input logic kind, input logic [kms_pkg::ROWS_W-1:0] levels,
                             input bit typed, input kms_pkg::t_result typed_res);
        kms_pkg::t_result want;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(kms_pkg::IN_TDATA_W-kms_pkg::ROWS_W){1'b0}}, levels};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = predict_scan_step(kind, levels);
        if (typed) want = typed_res;
        scan_results_due.push_back(want);
    endtask

    // Runs the current sweep out with released keys, then waits for every result.
    task automatic quiesce();
        while (sc_phase != kms_pkg::PH_IDLE) begin
            send_item(kms_pkg::KIND_TICK, '1, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (scan_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive edges; the block must be idle.
    task automatic write_settings(input logic [kms_pkg::WAIT_W-1:0] deb,
                                  input logic [kms_pkg::IDX_W-1:0] cols,
                                  input logic [kms_pkg::IDX_W-1:0] rows);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= kms_pkg::CFG_DEBOUNCE;
        i_cfg_data  <= deb;
        @(posedge i_clk);
        i_cfg_index <= kms_pkg::CFG_COLUMNS;
        i_cfg_data  <= {{(kms_pkg::CFG_DATA_W-kms_pkg::IDX_W){1'b0}}, cols};
        @(posedge i_clk);
        i_cfg_index <= kms_pkg::CFG_ROWS;
        i_cfg_data  <= {{(kms_pkg::CFG_DATA_W-kms_pkg::IDX_W){1'b0}}, rows};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg.debounce_ticks = deb;
        cfg.active_columns = cols;
        cfg.active_rows    = rows;
    endtask

    function automatic t_plan_row plan_item(input logic kind,
                                            input logic [kms_pkg::ROWS_W-1:0] levels);
        t_plan_row p;
        p = '{is_cfg: 1'b0, deb: '0, cols: '0, rows: '0, kind: kind, levels: levels,
              typed: 1'b0, res: '0};
        return p;
    endfunction

    function automatic t_plan_row plan_typed(input logic kind,
                                             input logic [kms_pkg::ROWS_W-1:0] levels,
                                             input logic [kms_pkg::DRIVE_W-1:0] drive,
                                             input logic done, input logic found,
                                             input logic [kms_pkg::CODE_W-1:0] code);
        t_plan_row p;
        p = plan_item(kind, levels);
        p.typed = 1'b1;
        p.res   = '{key_code: code, key_found: found, scan_done: done, column_drive: drive};
        return p;
    endfunction

    function automatic t_plan_row plan_cfg(input logic [kms_pkg::WAIT_W-1:0] deb,
                                           input logic [kms_pkg::IDX_W-1:0] cols,
                                           input logic [kms_pkg::IDX_W-1:0] rows);
        t_plan_row p;
        p = plan_item(kms_pkg::KIND_START, '0);
        p.is_cfg = 1'b1;
        p.deb    = deb;
        p.cols   = cols;
        p.rows   = rows;
        return p;
    endfunction

    // Receiver: random ready, with one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            m_axis_tready <= 1'b0;
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Each result transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        kms_pkg::t_result got;
        kms_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(kms_pkg::t_result)-1:0];
            if (scan_results_due.size() == 0) begin
                note_mismatch("result with nothing expected", got, 0);
            end else begin
                want = scan_results_due.pop_front();
                if (got.column_drive != want.column_drive)
                    note_mismatch("column_drive", got.column_drive, want.column_drive);
                if (got.scan_done != want.scan_done)
                    note_mismatch("scan_done", got.scan_done, want.scan_done);
                if (got.key_found != want.key_found)
                    note_mismatch("key_found", got.key_found, want.key_found);
                if (got.key_code != want.key_code)
                    note_mismatch("key_code", got.key_code, want.key_code);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic                       kind;
        logic [kms_pkg::ROWS_W-1:0] levels;
        logic [kms_pkg::WAIT_W-1:0] deb;
        logic [kms_pkg::IDX_W-1:0]  cols;
        logic [kms_pkg::IDX_W-1:0]  rows;
        logic [31:0]                rnd;

        sc_phase = kms_pkg::PH_IDLE;
        sc_col   = '0;
        sc_row   = '0;
        sc_wait  = '0;
        sc_code  = '0;
        sc_found = 1'b0;
        cfg.debounce_ticks = kms_pkg::DEFAULT_DEBOUNCE;
        cfg.active_columns = kms_pkg::DEFAULT_COLUMNS;
        cfg.active_rows    = kms_pkg::DEFAULT_ROWS;
        tx_idle_pct = 34;
        rx_idle_pct = 80;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed plan: tick while idle, zero counts, a start while busy,
        // no key versus key (0,0), zero and short debounce, unexamined row bits.
        plan.push_back(plan_typed(kms_pkg::KIND_TICK, 10'h000, DRIVE_IDLE, 1'b0, 1'b0, 7'd0));
        plan.push_back(plan_cfg(16'd0, 4'd0, 4'd0));
        plan.push_back(plan_typed(kms_pkg::KIND_START, 10'h3FF, 10'h3FE, 1'b0, 1'b0, 7'd0));
        plan.push_back(plan_typed(kms_pkg::KIND_START, 10'h000, 10'h3FE, 1'b0, 1'b0, 7'd0));
        plan.push_back(plan_typed(kms_pkg::KIND_TICK, 10'h3FF, DRIVE_IDLE, 1'b1, 1'b0, 7'd0));
        plan.push_back(plan_typed(kms_pkg::KIND_START, 10'h3FF, 10'h3FE, 1'b0, 1'b0, 7'd0));
        plan.push_back(plan_item(kms_pkg::KIND_TICK, 10'h3FE));
        plan.push_back(plan_item(kms_pkg::KIND_TICK, 10'h000));
        plan.push_back(plan_typed(kms_pkg::KIND_TICK, 10'h001, DRIVE_IDLE, 1'b1, 1'b1, 7'd0));
        plan.push_back(plan_cfg(16'd1, 4'd2, 4'd2));
        plan.push_back(plan_item(kms_pkg::KIND_START, 10'h155));
        plan.push_back(plan_item(kms_pkg::KIND_TICK, 10'h3FF));
        plan.push_back(plan_item(kms_pkg::KIND_TICK, 10'h3FD));
        plan.push_back(plan_item(kms_pkg::KIND_TICK, 10'h000));
        plan.push_back(plan_item(kms_pkg::KIND_TICK, 10'h3FF));
        plan.push_back(plan_item(kms_pkg::KIND_TICK, 10'h0AA));
        plan.push_back(plan_item(kms_pkg::KIND_TICK, 10'h3FF));
        plan.push_back(plan_item(kms_pkg::KIND_TICK, 10'h3FF));
        plan.push_back(plan_cfg(16'd0, 4'd1, 4'd1));
        plan.push_back(plan_item(kms_pkg::KIND_START, 10'h3FF));
        plan.push_back(plan_typed(kms_pkg::KIND_TICK, 10'h001, DRIVE_IDLE, 1'b1, 1'b0, 7'd0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                quiesce();
                write_settings(plan[i].deb, plan[i].cols, plan[i].rows);
            end else begin
                send_item(plan[i].kind, plan[i].levels, plan[i].typed, plan[i].res);
            end
        end

        // Random part in three idling modes, three register settings each.
        for (int mode = 0; mode < 3; mode++) begin
            for (int setting = 0; setting < 3; setting++) begin
                quiesce();
                if (setting == 2) begin
                    case (mode)
                        0: begin
                            deb = kms_pkg::DEFAULT_DEBOUNCE; cols = 4'd10; rows = 4'd10;
                        end
                        1: begin deb = 16'd0; cols = 4'd15; rows = 4'd15; end
                        default: begin deb = 16'd1; cols = 4'd10; rows = 4'd10; end
                    endcase
                end else begin
                    rnd  = $urandom_range(3);
                    deb  = rnd[kms_pkg::WAIT_W-1:0];
                    rnd  = $urandom_range(15);
                    cols = rnd[kms_pkg::IDX_W-1:0];
                    rnd  = $urandom_range(15);
                    rows = rnd[kms_pkg::IDX_W-1:0];
                end
                write_settings(deb, cols, rows);
                if (setting == 0) begin
                    tx_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 80 : 0;
                    rx_idle_pct = (mode == 0) ? 80 : (mode == 1) ? 34 : 0;
                    // With nobody idling, hold the receiver off while items keep coming.
                    if (mode == 2) hold_req <= hold_req + 1;
                end
                repeat (SETTING_ITEMS) begin
                    rnd    = $urandom;
                    levels = rnd[kms_pkg::ROWS_W-1:0];
                    if (sc_phase == kms_pkg::PH_IDLE) begin
                        kind = ($urandom_range(99) < 85) ? kms_pkg::KIND_START
                                                         : kms_pkg::KIND_TICK;
                    end else begin
                        kind = ($urandom_range(99) < 4) ? kms_pkg::KIND_START
                                                        : kms_pkg::KIND_TICK;
                    end
                    if (sc_phase == kms_pkg::PH_CHECK) begin
                        levels[sc_row] = ($urandom_range(99) >= 35);
                    end else if (sc_phase == kms_pkg::PH_RELEASE) begin
                        rnd = $urandom_range(1);
                        levels[sc_row] = rnd[0];
                    end
                    send_item(kind, levels, 1'b0, '0);
                end
            end
        end

        // A long debounce on both sides of one key press.
        quiesce();
        write_settings(16'd40, 4'd1, 4'd1);
        send_item(kms_pkg::KIND_START, '0, 1'b0, '0);
        rnd    = $urandom;
        levels = rnd[kms_pkg::ROWS_W-1:0];
        levels[0] = 1'b0;
        send_item(kms_pkg::KIND_TICK, levels, 1'b0, '0);
        while (sc_phase != kms_pkg::PH_IDLE) begin
            rnd    = $urandom;
            levels = rnd[kms_pkg::ROWS_W-1:0];
            levels[0] = 1'b1;
            send_item(kms_pkg::KIND_TICK, levels, 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (scan_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scan_results_due.size() != 0) begin
            note_mismatch("results never delivered", 0, scan_results_due.size());
        end

        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/kms_pkg.sv
src/kms_cfg_regs.sv
src/kms_scan_core.sv
src/keypad_matrix_scanner_unit.sv
src/kms_checker.sv
verif/testbench.sv
